// ===== rtl/qlsf_pkg.sv =====
// Shared types and constants of the quadratic least-squares fit block.
package qlsf_pkg;

  localparam int X_W    = 11;  // width of the coordinate fields
  localparam int COEF_W = 64;  // width of one coefficient field
  localparam int IN_W   = 24;  // x, y packed and padded to whole bytes
  localparam int OUT_W  = 3 * COEF_W;

  // Positions of the running sums in the sum vector.
  localparam int IDX_N    = 0;
  localparam int IDX_SY   = 5;
  localparam int N_SUMS   = 8;

  // Terms of a 3x3 determinant: column picked in rows 0, 1, 2.
  // The first three terms add, the last three subtract.
  localparam int N_TERMS     = 6;
  localparam int N_POS_TERMS = 3;
  localparam logic [2:0] LAST_TERM = 3'd5;
  localparam logic [1:0] TERM_COL [N_TERMS][3] = '{
    '{2'd0, 2'd1, 2'd2},
    '{2'd1, 2'd2, 2'd0},
    '{2'd2, 2'd0, 2'd1},
    '{2'd2, 2'd1, 2'd0},
    '{2'd1, 2'd0, 2'd2},
    '{2'd0, 2'd2, 2'd1}
  };

  // Determinant selectors: the normal matrix, then one per replaced column.
  localparam logic [1:0] DET_MAIN = 2'd0;
  localparam logic [1:0] DET_LAST = 2'd3;

  localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  // Commands from the controller to the solver datapath.
  typedef struct packed {
    logic       load_a;      // P = 0, M = first factor, Q = second factor
    logic       load_b;      // M = P, Q = third factor, P = 0
    logic       mul_step;    // one shift-add step
    logic       det_clr;     // clear determinant accumulator
    logic       det_add;     // add or subtract the finished product
    logic       save_d;      // keep the normal determinant
    logic       div_init;    // load dividend and divisor magnitudes
    logic       div_step;    // one restoring division step
    logic       round_q;     // round the quotient to nearest
    logic       store_coef;  // saturate and store one coefficient
    logic [1:0] det_sel;
    logic [2:0] term;
  } qlsf_cmd_t;

  // Controller outputs toward the stream ports and the accumulator.
  typedef struct packed {
    logic in_ready;
    logic finish;    // load result beat and clear the sums
    logic singular;
  } qlsf_ctl_t;

endpackage

// ===== rtl/qlsf_accum.sv =====
// Point accumulator: pipelined power products and exact running sums.
module qlsf_accum #(
  parameter int CW = 11,
  parameter int NB = 17,
  parameter int W4 = 61
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_take,
  input  logic [qlsf_pkg::X_W-1:0]             x_coord,
  input  logic [qlsf_pkg::X_W-1:0]             y_coord,
  input  logic                                 clear,
  output logic                                 busy,
  output logic [qlsf_pkg::N_SUMS-1:0][W4-1:0]  sums
);
  import qlsf_pkg::*;

  logic [NB-1:0]      point_count;
  logic [NB+CW-1:0]   sum_x, sum_y;
  logic [NB+2*CW-1:0] sum_x_sq, sum_xy;
  logic [NB+3*CW-1:0] sum_x_cube, sum_x_sq_y;
  logic [NB+4*CW-1:0] sum_x_quad;

  logic            v1, v2;
  logic [CW-1:0]   x1, y1, x2d, y2d;
  logic [2*CW-1:0] sq1, xy1, sq2, xy2;
  logic [3*CW-1:0] cube2, sqy2;
  logic [4*CW-1:0] quad2;
  logic            keep;

  // Drop points once the count is full.
  assign keep = in_take && !point_count[NB-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= keep;
      v2 <= v1;
    end
    x1  <= x_coord[CW-1:0];
    y1  <= y_coord[CW-1:0];
    sq1 <= x_coord[CW-1:0] * x_coord[CW-1:0];
    xy1 <= x_coord[CW-1:0] * y_coord[CW-1:0];
    x2d   <= x1;
    y2d   <= y1;
    sq2   <= sq1;
    xy2   <= xy1;
    cube2 <= sq1 * x1;
    quad2 <= sq1 * sq1;
    sqy2  <= sq1 * y1;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      point_count <= '0;
      sum_x       <= '0;
      sum_x_sq    <= '0;
      sum_x_cube  <= '0;
      sum_x_quad  <= '0;
      sum_y       <= '0;
      sum_xy      <= '0;
      sum_x_sq_y  <= '0;
    end else begin
      if (keep) point_count <= point_count + NB'(1);
      if (v2) begin
        sum_x      <= sum_x + (NB+CW)'(x2d);
        sum_x_sq   <= sum_x_sq + (NB+2*CW)'(sq2);
        sum_x_cube <= sum_x_cube + (NB+3*CW)'(cube2);
        sum_x_quad <= sum_x_quad + (NB+4*CW)'(quad2);
        sum_y      <= sum_y + (NB+CW)'(y2d);
        sum_xy     <= sum_xy + (NB+2*CW)'(xy2);
        sum_x_sq_y <= sum_x_sq_y + (NB+3*CW)'(sqy2);
      end
    end
  end

  assign busy = v1 | v2;
  assign sums[IDX_N]  = W4'(point_count);
  assign sums[1]      = W4'(sum_x);
  assign sums[2]      = W4'(sum_x_sq);
  assign sums[3]      = W4'(sum_x_cube);
  assign sums[4]      = W4'(sum_x_quad);
  assign sums[IDX_SY] = W4'(sum_y);
  assign sums[6]      = W4'(sum_xy);
  assign sums[7]      = W4'(sum_x_sq_y);

endmodule

// ===== rtl/qlsf_dp.sv =====
// Solver datapath: serial multiplier, determinant accumulator, divider, rounding.
module qlsf_dp #(
  parameter int W4   = 61,
  parameter int FRAC = 32
) (
  input  logic                                      clk,
  input  qlsf_pkg::qlsf_cmd_t                       cmd,
  input  logic [qlsf_pkg::N_SUMS-1:0][W4-1:0]       sums,
  output logic                                      d_zero,
  output logic [2:0][qlsf_pkg::COEF_W-1:0]          coefs
);
  import qlsf_pkg::*;

  localparam int PW = 3 * W4;
  localparam int DW = PW + 3;
  localparam int NW = DW + FRAC;
  localparam int RW = DW + 1;

  logic [PW-1:0]        mcand, prod;
  logic [W4-1:0]        mplier;
  logic signed [DW-1:0] det, dreg;
  logic [NW-1:0]        nreg, quot;
  logic [RW-1:0]        rem, rem_sh;
  logic [DW-1:0]        dmag, nmag;
  logic                 neg;
  logic [1:0]           tc0, tc1, tc2;
  logic [W4-1:0]        fa, fb, fc;
  logic [COEF_W-1:0]    sat_val;
  logic                 pos_over, neg_over;

  // Matrix entry (row r, column c) of the selected determinant.
  function automatic logic [W4-1:0] elem(input logic [1:0] r, input logic [1:0] c,
                                         input logic [1:0] k,
                                         input logic [N_SUMS-1:0][W4-1:0] s);
    logic [2:0] ix;
    if (k != DET_MAIN && c == k - 2'd1) ix = 3'(IDX_SY) + 3'(r);
    else                                 ix = 3'(r) + 3'(c);
    return s[ix];
  endfunction

  assign tc0 = TERM_COL[cmd.term][0];
  assign tc1 = TERM_COL[cmd.term][1];
  assign tc2 = TERM_COL[cmd.term][2];
  assign fa  = elem(2'd0, tc0, cmd.det_sel, sums);
  assign fb  = elem(2'd1, tc1, cmd.det_sel, sums);
  assign fc  = elem(2'd2, tc2, cmd.det_sel, sums);

  assign rem_sh = {rem[RW-2:0], nreg[NW-1]};
  assign nmag   = det[DW-1] ? DW'(-det) : DW'(det);

  always_ff @(posedge clk) begin
    if (cmd.load_a) begin
      mcand  <= PW'(fa);
      mplier <= fb;
      prod   <= '0;
    end else if (cmd.load_b) begin
      mcand  <= prod;
      mplier <= fc;
      prod   <= '0;
    end else if (cmd.mul_step) begin
      if (mplier[0]) prod <= prod + mcand;
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end

    if (cmd.det_clr) det <= '0;
    else if (cmd.det_add) begin
      if (cmd.term < 3'(N_POS_TERMS)) det <= det + DW'(prod);
      else                            det <= det - DW'(prod);
    end
    if (cmd.save_d) dreg <= det;

    if (cmd.div_init) begin
      neg  <= det[DW-1] ^ dreg[DW-1];
      nreg <= {nmag, {FRAC{1'b0}}};
      dmag <= dreg[DW-1] ? DW'(-dreg) : DW'(dreg);
      rem  <= '0;
      quot <= '0;
    end else if (cmd.div_step) begin
      nreg <= nreg << 1;
      if (rem_sh >= RW'(dmag)) begin
        rem  <= rem_sh - RW'(dmag);
        quot <= {quot[NW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        quot <= {quot[NW-2:0], 1'b0};
      end
    end else if (cmd.round_q) begin
      if ({rem, 1'b0} >= (RW+1)'(dmag)) quot <= quot + NW'(1);
    end

    if (cmd.store_coef) coefs[2'(cmd.det_sel - 2'd1)] <= sat_val;
  end

  // Saturate the rounded magnitude to the signed coefficient range.
  assign pos_over = |quot[NW-1:COEF_W-1];
  assign neg_over = (|quot[NW-1:COEF_W]) || (quot[COEF_W-1] && (|quot[COEF_W-2:0]));
  always_comb begin
    if (neg) sat_val = neg_over ? COEF_MIN : COEF_W'(-quot[COEF_W-1:0]);
    else     sat_val = pos_over ? COEF_MAX : quot[COEF_W-1:0];
  end

  assign d_zero = (dreg == '0);

endmodule

// ===== rtl/qlsf_ctrl.sv =====
// Solve sequencer: walks terms, determinants, division and result hand-off.
module qlsf_ctrl #(
  parameter int W4 = 61,
  parameter int NW = 218
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_last,
  input  logic                acc_busy,
  input  logic                d_zero,
  input  logic                out_free,
  output qlsf_pkg::qlsf_cmd_t cmd,
  output qlsf_pkg::qlsf_ctl_t ctl
);
  import qlsf_pkg::*;

  localparam int CNTW = $clog2(NW + 1);
  localparam logic [CNTW-1:0] MUL_LAST = CNTW'(W4 - 1);
  localparam logic [CNTW-1:0] DIV_LAST = CNTW'(NW - 1);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_DRAIN = 14'b00000000000010,
    S_LOADA = 14'b00000000000100,
    S_MULA  = 14'b00000000001000,
    S_LOADB = 14'b00000000010000,
    S_MULB  = 14'b00000000100000,
    S_ADD   = 14'b00000001000000,
    S_SAVE  = 14'b00000010000000,
    S_CHECK = 14'b00000100000000,
    S_DIVI  = 14'b00001000000000,
    S_DIV   = 14'b00010000000000,
    S_ROUND = 14'b00100000000000,
    S_STORE = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  state_t          state, state_next;
  logic [CNTW-1:0] cnt;
  logic [2:0]      term;
  logic [1:0]      sel;
  logic            sing;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.det_sel  = sel;
    cmd.term     = term;
    ctl.in_ready = 1'b0;
    ctl.finish   = 1'b0;
    ctl.singular = sing;
    unique case (state)
      S_IDLE: begin
        ctl.in_ready = 1'b1;
        if (in_last) state_next = S_DRAIN;
      end
      S_DRAIN: if (!acc_busy) state_next = S_LOADA;
      S_LOADA: begin
        cmd.load_a  = 1'b1;
        cmd.det_clr = (term == 3'd0);
        state_next  = S_MULA;
      end
      S_MULA: begin
        cmd.mul_step = 1'b1;
        if (cnt == MUL_LAST) state_next = S_LOADB;
      end
      S_LOADB: begin
        cmd.load_b = 1'b1;
        state_next = S_MULB;
      end
      S_MULB: begin
        cmd.mul_step = 1'b1;
        if (cnt == MUL_LAST) state_next = S_ADD;
      end
      S_ADD: begin
        cmd.det_add = 1'b1;
        if (term != LAST_TERM)     state_next = S_LOADA;
        else if (sel == DET_MAIN)  state_next = S_SAVE;
        else                       state_next = S_DIVI;
      end
      S_SAVE: begin
        cmd.save_d = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: state_next = d_zero ? S_DONE : S_LOADA;
      S_DIVI: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == DIV_LAST) state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round_q = 1'b1;
        state_next  = S_STORE;
      end
      S_STORE: begin
        cmd.store_coef = 1'b1;
        state_next     = (sel == DET_LAST) ? S_DONE : S_LOADA;
      end
      S_DONE: begin
        if (out_free) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      term  <= '0;
      sel   <= DET_MAIN;
      sing  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state == S_MULA || state == S_MULB || state == S_DIV) ? cnt + CNTW'(1) : '0;
      if (state == S_ADD) term <= (term == LAST_TERM) ? 3'd0 : term + 3'd1;
      if (state == S_IDLE) begin
        sel  <= DET_MAIN;
        sing <= 1'b0;
        term <= 3'd0;
      end
      if (state == S_CHECK) begin
        sel  <= 2'd1;
        sing <= d_zero;
      end
      if (state == S_STORE) sel <= sel + 2'd1;
    end
  end

endmodule

// ===== rtl/quadratic_least_squares_fit.sv =====
// Top level of the quadratic least-squares fit: ports, result register, assertions.
//
//  Channel   Dir  Beat contents
//  s_*       in   tdata: x_coord[10:0], y_coord[21:11], pad; tlast: last_point
//  m_*       out  tdata: coef_const, coef_linear, coef_square; tuser: singular
//
// Points stream in at one beat per cycle; each is summed through a three-stage
// multiply/add pipeline. A beat with tlast starts the solve, during which
// s_tready is low. The solve forms the four determinants, six terms each, on
// the bit-serial multiplier (W4 = COUNT_BITS+1+4*coordinate bits), then runs
// three restoring divisions of NW = 3*W4+3+FRAC_BITS quotient bits each; a
// singular set skips the divisions and the remaining determinants.
// Reset (rst, synchronous) clears the sums, the sequencer and m_tvalid.
// The result beat holds in its register until taken; points are accepted
// meanwhile, and a following solve waits only to hand over its result.
module quadratic_least_squares_fit #(
  parameter int COORD_BITS = 11,
  parameter int COUNT_BITS = 16,
  parameter int FRAC_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [qlsf_pkg::IN_W-1:0]    s_tdata,   // x_coord, y_coord (low bits up)
  input  logic                         s_tlast,   // last_point
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [qlsf_pkg::OUT_W-1:0]   m_tdata,   // coef_const, coef_linear, coef_square
  output logic                         m_tuser    // singular
);
  import qlsf_pkg::*;

  // Only the low coordinate bits that the field carries take part.
  localparam int CW = (COORD_BITS < X_W) ? COORD_BITS : X_W;
  localparam int NB = COUNT_BITS + 1;
  localparam int W4 = NB + 4 * CW;
  localparam int NW = 3 * W4 + 3 + FRAC_BITS;

  logic                         in_take;
  logic                         acc_busy;
  logic                         d_zero;
  logic                         out_free;
  logic [N_SUMS-1:0][W4-1:0]    sums;
  logic [2:0][COEF_W-1:0]       coefs;
  qlsf_cmd_t                    cmd;
  qlsf_ctl_t                    ctl;

  assign s_tready = ctl.in_ready;
  assign in_take  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  qlsf_accum #(.CW(CW), .NB(NB), .W4(W4)) u_accum (
    .clk     (clk),
    .rst     (rst),
    .in_take (in_take),
    .x_coord (s_tdata[X_W-1:0]),
    .y_coord (s_tdata[2*X_W-1:X_W]),
    .clear   (ctl.finish),
    .busy    (acc_busy),
    .sums    (sums)
  );

  qlsf_ctrl #(.W4(W4), .NW(NW)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_last  (in_take && s_tlast),
    .acc_busy (acc_busy),
    .d_zero   (d_zero),
    .out_free (out_free),
    .cmd      (cmd),
    .ctl      (ctl)
  );

  qlsf_dp #(.W4(W4), .FRAC(FRAC_BITS)) u_dp (
    .clk    (clk),
    .cmd    (cmd),
    .sums   (sums),
    .d_zero (d_zero),
    .coefs  (coefs)
  );

  // Result register: load on finish, drop valid once the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (ctl.finish) begin
      m_tdata <= ctl.singular ? '0 : {coefs[2], coefs[1], coefs[0]};
      m_tuser <= ctl.singular;
    end
  end

  // A singular fit carries all-zero coefficients.
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("singular result with nonzero coefficients");

  // The last point of a set closes the input until the solve is done.
  a_solve_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("input open right after a last point");

  // A waiting result beat holds its contents.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("pending result beat changed");

endmodule

// ===== tb/sv/qlsf_checker.sv =====
// Checker for the quadratic fit: mirrors the point sums, predicts each fit, compares results.
`timescale 1ns / 100ps

module qlsf_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [qlsf_pkg::IN_W-1:0]   s_tdata,
  input  logic                        s_tlast,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [qlsf_pkg::OUT_W-1:0]  m_tdata,
  input  logic                        m_tuser,
  output int                          errors,
  output int                          fits_waiting
);
  import qlsf_pkg::*;

  localparam int FRAC   = 32;
  localparam int CNT_LIM = 1 << 16;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [63:0] c0;
    logic signed [63:0] c1;
    logic signed [63:0] c2;
    logic               sing;
  } fit_t;

  fit_t  fit_q[$];
  wide_t n_pts, s_x, s_xx, s_x3, s_x4, s_y, s_xy, s_xxy;

  function automatic wide_t det3(wide_t m[9]);
    return m[0]*m[4]*m[8] + m[1]*m[5]*m[6] + m[2]*m[3]*m[7]
         - m[2]*m[4]*m[6] - m[1]*m[3]*m[8] - m[0]*m[5]*m[7];
  endfunction

  // Round num/den * 2^FRAC to nearest, ties away from zero, then saturate.
  function automatic logic signed [63:0] to_fixed(wide_t num, wide_t den);
    logic  neg;
    wide_t n, d, q, r;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    n = n <<< FRAC;
    q = n / d;
    r = n % d;
    if (2 * r >= d) q = q + 1;
    if (!neg) return ((q >>> 63) != 0) ? COEF_MAX : q[63:0];
    if (q > (wide_t'(1) <<< 63)) return COEF_MIN;
    return -q[63:0];
  endfunction

  function automatic fit_t solve_fit();
    wide_t mat[9], rep[9], rhs[3], dm;
    fit_t  f;
    mat = '{n_pts, s_x, s_xx, s_x, s_xx, s_x3, s_xx, s_x3, s_x4};
    rhs = '{s_y, s_xy, s_xxy};
    dm = det3(mat);
    f = '{64'sd0, 64'sd0, 64'sd0, 1'b1};
    if (dm == 0) return f;
    f.sing = 1'b0;
    for (int c = 0; c < 3; c++) begin
      rep = mat;
      for (int k = 0; k < 3; k++) rep[k*3 + c] = rhs[k];
      case (c)
        0: f.c0 = to_fixed(det3(rep), dm);
        1: f.c1 = to_fixed(det3(rep), dm);
        default: f.c2 = to_fixed(det3(rep), dm);
      endcase
    end
    return f;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  initial begin
    errors = 0;
    fits_waiting = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      n_pts = 0; s_x = 0; s_xx = 0; s_x3 = 0; s_x4 = 0; s_y = 0; s_xy = 0; s_xxy = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        wide_t x, y;
        x = wide_t'(s_tdata[X_W-1:0]);
        y = wide_t'(s_tdata[2*X_W-1:X_W]);
        // points past the counter limit are dropped, the mark still counts
        if (n_pts < CNT_LIM) begin
          n_pts += 1; s_x += x; s_xx += x*x; s_x3 += x*x*x; s_x4 += x*x*x*x;
          s_y += y; s_xy += x*y; s_xxy += x*x*y;
        end
        if (s_tlast) begin
          fit_q.insert(fit_q.size(), solve_fit());
          n_pts = 0; s_x = 0; s_xx = 0; s_x3 = 0; s_x4 = 0; s_y = 0; s_xy = 0; s_xxy = 0;
        end
      end
      if (m_tvalid && m_tready) begin
        if (fit_q.size() == 0) begin
          report("unexpected beat", m_tdata[63:0], 64'd0);
        end else begin
          fit_t w;
          w = fit_q.pop_front();
          if (m_tdata[63:0] !== w.c0) report("coef_const", m_tdata[63:0], w.c0);
          if (m_tdata[127:64] !== w.c1) report("coef_linear", m_tdata[127:64], w.c1);
          if (m_tdata[191:128] !== w.c2) report("coef_square", m_tdata[191:128], w.c2);
          if (m_tuser !== w.sing) report("singular", m_tuser, w.sing);
        end
      end
      fits_waiting = fit_q.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench top: drives point sets into the quadratic fit and gives the verdict.
`timescale 1ns / 100ps

module testbench;
  import qlsf_pkg::*;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata;   // x_coord, y_coord, pad (low bits up)
  logic                s_tlast;   // last_point
  logic                m_tvalid;
  logic                m_tready;
  logic [OUT_W-1:0]    m_tdata;   // coef_const, coef_linear, coef_square
  logic                m_tuser;   // singular

  int errors;
  int fits_waiting;
  int hold_req;       // long receiver hold-off requested by the sender, in cycles
  bit calm;           // no new random gaps or stalls on either side while set

  localparam int SOLVE_CYC = 4000;   // a little over one full solve

  quadratic_least_squares_fit i_dut (.*);

  qlsf_checker i_chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .errors, .fits_waiting
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #150ms;
    $display("TB_ERROR");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if (calm) return 0;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9: return 0;
      19:                           return $urandom_range(20, 150);
      default:                      return $urandom_range(1, 4);
    endcase
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    stall = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        m_tready <= 1'b0;
        hold_req--;
      end else if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        if (!rst && !calm) stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  // Offer one point; hold valid until the beat is taken.
  task automatic send_point(logic [X_W-1:0] x, logic [X_W-1:0] y, logic last, int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, y, x};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_set(int len, int x_span, bit edge_vals);
    logic [X_W-1:0] x, y;
    int base;
    base = $urandom_range(0, 2047 - x_span);
    for (int i = 0; i < len; i++) begin
      x = X_W'(base + int'($urandom_range(0, x_span)));
      y = X_W'($urandom_range(0, 2047));
      if (edge_vals && $urandom_range(0, 3) == 0) x = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
      if (edge_vals && $urandom_range(0, 3) == 0) y = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
      send_point(x, y, i == len - 1, pick_gap());
    end
  endtask

  // Let the queue drain, then allow a full solve to finish.
  task automatic drain();
    s_tvalid <= 1'b0;
    wait (fits_waiting == 0);
    repeat (SOLVE_CYC) @(posedge clk);
  endtask

  initial begin
    int sent, len;
    bit held, drained;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    hold_req = 0;
    calm = 1'b1;
    held = 1'b0;
    drained = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: exact parabola, field extremes, single and two-point sets,
    // repeated x (singular), and an all-ones/all-zeros mix.
    send_point(11'd0, 11'd0, 1'b0, 0);
    send_point(11'd1, 11'd1, 1'b0, 0);
    send_point(11'd2, 11'd4, 1'b1, 0);
    send_point(11'd5, 11'd7, 1'b1, 0);
    send_point(11'd3, 11'd9, 1'b0, 0);
    send_point(11'd8, 11'd1, 1'b1, 0);
    send_point(11'd9, 11'd100, 1'b0, 0);
    send_point(11'd9, 11'd200, 1'b0, 0);
    send_point(11'd9, 11'd300, 1'b1, 0);
    send_point(11'h7FF, 11'h7FF, 1'b0, 0);
    send_point(11'h000, 11'h7FF, 1'b0, 0);
    send_point(11'h400, 11'h000, 1'b0, 0);
    send_point(11'h3FF, 11'h555, 1'b1, 0);
    send_point(11'h000, 11'h000, 1'b0, 0);
    send_point(11'h7FE, 11'h2AA, 1'b0, 0);
    send_point(11'h7FF, 11'h000, 1'b1, 0);
    drain();

    // Random sets.
    calm = 1'b0;
    sent = 0;
    while (sent < 750) begin
      if (!held && sent > 200) begin
        // receiver holds off while two sets are pushed behind a pending result
        held = 1'b1;
        hold_req = 8000;
        calm = 1'b1;
        send_set(4, 2047, 1'b0);
        send_set(5, 2047, 1'b0);
        calm = 1'b0;
        sent += 9;
        continue;
      end
      if (!drained && sent > 450) begin
        drained = 1'b1;
        drain();
        continue;
      end
      if ($urandom_range(0, 4) == 0) calm = ~calm;
      case ($urandom_range(0, 9))
        0:       len = $urandom_range(1, 2);
        1:       len = $urandom_range(20, 40);
        default: len = $urandom_range(3, 10);
      endcase
      case ($urandom_range(0, 5))
        0:       send_set(len, 2, 1'b0);
        1:       send_set(len, 20, 1'b0);
        2:       send_set(len, 2047, 1'b1);
        default: send_set(len, 2047, 1'b0);
      endcase
      sent += len;
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;
    wait (fits_waiting == 0);
    repeat (SOLVE_CYC) @(posedge clk);

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
